FILE: design/loop_region_trigger_sequencer_unit_macros.svh
// Assertion macros for the loop region trigger sequencer.
// Included by every RTL file that carries concurrent assertions.
`ifndef LOOP_REGION_TRIGGER_SEQUENCER_UNIT_MACROS_SVH
`define LOOP_REGION_TRIGGER_SEQUENCER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lrts_pkg.sv
// Shared constants, codes and types of the loop region trigger sequencer.
// Used by the region memory, the sequencer core, the event output and the top level.
package lrts_pkg;

   localparam int REGION_SLOTS = 32;
   localparam int SLOT_W       = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int CNT_W        = $clog2(REGION_SLOTS + 1);
   localparam int MAX_EVENTS   = 32;
   localparam int EVT_CNT_W    = $clog2(MAX_EVENTS + 1);

   localparam int POS_W      = 16;
   localparam int UT_W       = 28;
   localparam int ELAPSED_W  = 30;
   localparam int PH_W       = 48;
   localparam int PROD_W     = POS_W + 1 + UT_W;
   localparam int IN_SLOT_W  = 5;
   localparam int EVT_SLOT_W = 5;
   localparam int OP_W       = 2;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = UT_W;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;

   // Request operations.
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
   localparam logic [OP_W-1:0] OP_TOGGLE = 2'd2;

   // Event kinds.
   localparam logic [KIND_W-1:0] EV_SAMPLE_ON = 2'd0;
   localparam logic [KIND_W-1:0] EV_MIDI_ON   = 2'd1;
   localparam logic [KIND_W-1:0] EV_MIDI_OFF  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_BEGIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_FINISH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_TIME   = 2'd2;

   localparam logic [POS_W-1:0] LOOP_BEGIN_RST  = 16'd0;
   localparam logic [POS_W-1:0] LOOP_FINISH_RST = 16'd1000;
   localparam logic [UT_W-1:0]  UNIT_TIME_RST   = 28'd2000000;

   typedef struct packed {
      logic [UT_W-1:0]  unit_time;
      logic [POS_W-1:0] loop_finish;
      logic [POS_W-1:0] loop_begin;
   } cfg_type;

   typedef struct packed {
      logic                 enable_slot;
      logic                 is_midi;
      logic [POS_W-1:0]     span;
      logic [POS_W-1:0]     start_pos;
      logic [IN_SLOT_W-1:0] slot;
      logic [ELAPSED_W-1:0] elapsed;
   } req_type;

   typedef struct packed {
      logic             is_midi;
      logic [POS_W-1:0] span;
      logic [POS_W-1:0] start_pos;
   } region_type;

   typedef struct packed {
      logic                  push_valid;
      logic [EVT_SLOT_W-1:0] slot;
      logic [KIND_W-1:0]     kind;
      logic                  flush;
   } evt_ctl_type;

endpackage

FILE: design/lrts_region_ram.sv
// Region table memory: start, span and kind of every slot.
// One write port, one read port with registered read data; uses lrts_pkg.
module lrts_region_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [lrts_pkg::SLOT_W-1:0] wr_addr,
   input  lrts_pkg::region_type       wr_data,
   input  logic                       rd_en,
   input  logic [lrts_pkg::SLOT_W-1:0] rd_addr,
   output lrts_pkg::region_type       rd_data
);
   import lrts_pkg::*;

   region_type mem_ff [REGION_SLOTS];
   region_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/lrts_event_out.sv
// Event output stage: one pending event plus the response register.
// The pending event is held until the next one arrives or the walk ends, to mark last.
`include "loop_region_trigger_sequencer_unit_macros.svh"
module lrts_event_out (
   input  logic                             clock,
   input  logic                             reset,
   input  lrts_pkg::evt_ctl_type            ctl,
   output logic                             evt_room,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lrts_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [lrts_pkg::KIND_W-1:0]      rsp_tuser,
   output logic                             rsp_tlast
);
   import lrts_pkg::*;

   logic                  pend_valid_ff, pend_valid_in;
   logic [EVT_SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic [KIND_W-1:0]     pend_kind_ff, pend_kind_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EVT_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  out_free;
   logic                  load;
   logic                  load_last;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign evt_room = !pend_valid_ff || out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_kind_in  = pend_kind_ff;
      load          = 1'b0;
      load_last     = 1'b0;
      if (ctl.push_valid && evt_room) begin
         // A newer event shows the pending one was not the last of the tick.
         load          = pend_valid_ff;
         pend_valid_in = 1'b1;
         pend_slot_in  = ctl.slot;
         pend_kind_in  = ctl.kind;
      end else if (ctl.flush && pend_valid_ff && out_free) begin
         load          = 1'b1;
         load_last     = 1'b1;
         pend_valid_in = 1'b0;
      end
      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_slot_in  = load ? pend_slot_ff : rsp_slot_ff;
      rsp_kind_in  = load ? pend_kind_ff : rsp_kind_ff;
      rsp_last_in  = load ? load_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_slot_ff <= pend_slot_in;
      pend_kind_ff <= pend_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_slot_ff);
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `LRTS_ASSERT_NOW(a_push_flush_excl, clock, reset, ctl.flush, !ctl.push_valid, "push during flush")
   `LRTS_ASSERT_NEXT(a_flush_sets_last, clock, reset, ctl.flush && pend_valid_ff && out_free, rsp_tvalid && rsp_tlast, "final event not marked last")
   `LRTS_ASSERT_NEXT(a_push_keeps_pend, clock, reset, ctl.push_valid && evt_room && pend_valid_ff, pend_valid_ff && rsp_tvalid && !rsp_tlast, "displaced event lost or marked last")

endmodule

FILE: design/lrts_sequencer.sv
// Sequencer core: playhead, play flag, slot marks and the walk over the region memory.
// Uses lrts_pkg and lrts_region_ram; events leave through lrts_event_out.
`include "loop_region_trigger_sequencer_unit_macros.svh"
module lrts_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  lrts_pkg::cfg_type           cfg,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [lrts_pkg::OP_W-1:0]   req_op,
   input  lrts_pkg::req_type           req,
   output lrts_pkg::evt_ctl_type       ctl,
   input  logic                        evt_room
);
   import lrts_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WRAP  = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_DRAIN = 4'b1000
   } seq_state_type;

   seq_state_type         state_ff, state_in;
   logic                  playing_ff, playing_in;
   logic [PH_W-1:0]       playhead_ff, playhead_in;
   logic [REGION_SLOTS-1:0] used_ff, used_in;
   logic [REGION_SLOTS-1:0] fired_ff, fired_in;
   logic [REGION_SLOTS-1:0] stopped_ff, stopped_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  v1_ff, v1_in;
   logic [SLOT_W-1:0]     idx1_ff, idx1_in;
   logic                  v2_ff, v2_in;
   logic [SLOT_W-1:0]     idx2_ff, idx2_in;
   logic                  kind2_ff, kind2_in;
   logic [PROD_W-1:0]     prod_lo_ff, prod_lo_in;
   logic [PROD_W-1:0]     prod_hi_ff, prod_hi_in;
   logic [EVT_CNT_W-1:0]  evt_cnt_ff, evt_cnt_in;

   logic                  req_acc;
   logic                  slot_ok;
   logic [SLOT_W-1:0]     wr_idx;
   logic                  ram_we;
   logic                  ram_re;
   region_type            ram_wr;
   region_type            ram_rd;
   logic [POS_W-1:0]      mul_a;
   logic [POS_W:0]        mul_b;
   logic [PROD_W-1:0]     mul_lo;
   logic [PROD_W-1:0]     mul_hi;
   logic                  rd_more;
   logic                  walk_done;
   logic                  slot_used;
   logic                  start_hit;
   logic                  stop_hit;
   logic                  emit;
   logic                  advance;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign slot_ok    = (7'(req.slot) < 7'(REGION_SLOTS));
   assign wr_idx     = SLOT_W'(req.slot);

   assign ram_wr.is_midi   = req.is_midi;
   assign ram_wr.span      = req.span;
   assign ram_wr.start_pos = req.start_pos;

   lrts_region_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx),
      .wr_data (ram_wr),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff[SLOT_W-1:0]),
      .rd_data (ram_rd)
   );

   // The two multipliers give the loop bounds when a tick is taken and the
   // region bounds during the walk.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         mul_a = cfg.loop_begin;
         mul_b = {1'b0, cfg.loop_finish};
      end else begin
         mul_a = ram_rd.start_pos;
         mul_b = (POS_W + 1)'(ram_rd.start_pos) + (POS_W + 1)'(ram_rd.span);
      end
   end

   assign mul_lo = PROD_W'(mul_a) * PROD_W'(cfg.unit_time);
   assign mul_hi = PROD_W'(mul_b) * PROD_W'(cfg.unit_time);

   assign rd_more   = (rd_idx_ff < CNT_W'(REGION_SLOTS));
   assign walk_done = !rd_more && !v1_ff && !v2_ff;
   assign slot_used = used_ff[idx2_ff];
   assign start_hit = !fired_ff[idx2_ff] && (playhead_ff >= PH_W'(prod_lo_ff))
                      && (playhead_ff < PH_W'(prod_hi_ff));
   assign stop_hit  = fired_ff[idx2_ff] && !stopped_ff[idx2_ff]
                      && (playhead_ff > PH_W'(prod_hi_ff));
   assign emit      = (state_ff == ST_WALK) && v2_ff && slot_used
                      && (start_hit || (stop_hit && kind2_ff))
                      && (evt_cnt_ff < EVT_CNT_W'(MAX_EVENTS));
   assign advance   = !emit || evt_room;

   always_comb begin
      ctl.push_valid = emit;
      ctl.slot       = EVT_SLOT_W'(idx2_ff);
      ctl.kind       = start_hit ? (kind2_ff ? EV_MIDI_ON : EV_SAMPLE_ON) : EV_MIDI_OFF;
      ctl.flush      = (state_ff == ST_DRAIN);
   end

   always_comb begin
      state_in    = state_ff;
      playing_in  = playing_ff;
      playhead_in = playhead_ff;
      used_in     = used_ff;
      fired_in    = fired_ff;
      stopped_in  = stopped_ff;
      rd_idx_in   = rd_idx_ff;
      v1_in       = v1_ff;
      idx1_in     = idx1_ff;
      v2_in       = v2_ff;
      idx2_in     = idx2_ff;
      kind2_in    = kind2_ff;
      prod_lo_in  = prod_lo_ff;
      prod_hi_in  = prod_hi_ff;
      evt_cnt_in  = evt_cnt_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_op)
                  OP_TICK: begin
                     if (playing_ff) begin
                        playhead_in = playhead_ff + PH_W'(req.elapsed);
                        prod_lo_in  = mul_lo;
                        prod_hi_in  = mul_hi;
                        rd_idx_in   = '0;
                        evt_cnt_in  = '0;
                        state_in    = ST_WRAP;
                     end
                  end
                  OP_WRITE: begin
                     if (slot_ok) begin
                        ram_we             = 1'b1;
                        used_in[wr_idx]    = req.enable_slot;
                        fired_in[wr_idx]   = 1'b0;
                        stopped_in[wr_idx] = 1'b0;
                     end
                  end
                  OP_TOGGLE: begin
                     fired_in   = '0;
                     stopped_in = '0;
                     playing_in = !playing_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WRAP: begin
            if (playhead_ff > PH_W'(prod_hi_ff)) begin
               playhead_in = PH_W'(prod_lo_ff);
               fired_in    = '0;
               stopped_in  = '0;
            end
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_DRAIN;
            end else if (advance) begin
               // Three stages: memory read, bound products, mark test.
               ram_re   = rd_more;
               v1_in    = rd_more;
               idx1_in  = rd_idx_ff[SLOT_W-1:0];
               if (rd_more) begin
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
               end
               v2_in    = v1_ff;
               idx2_in  = idx1_ff;
               kind2_in = ram_rd.is_midi;
               if (v1_ff) begin
                  prod_lo_in = mul_lo;
                  prod_hi_in = mul_hi;
               end
               if (v2_ff && slot_used) begin
                  if (start_hit) begin
                     fired_in[idx2_ff] = 1'b1;
                  end else if (stop_hit) begin
                     stopped_in[idx2_ff] = 1'b1;
                  end
               end
               if (emit) begin
                  evt_cnt_in = evt_cnt_ff + EVT_CNT_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (evt_room) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         playing_ff  <= 1'b0;
         playhead_ff <= '0;
         used_ff     <= '0;
         fired_ff    <= '0;
         stopped_ff  <= '0;
         rd_idx_ff   <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         evt_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         playing_ff  <= playing_in;
         playhead_ff <= playhead_in;
         used_ff     <= used_in;
         fired_ff    <= fired_in;
         stopped_ff  <= stopped_in;
         rd_idx_ff   <= rd_idx_in;
         v1_ff       <= v1_in;
         v2_ff       <= v2_in;
         evt_cnt_ff  <= evt_cnt_in;
      end
      idx1_ff    <= idx1_in;
      idx2_ff    <= idx2_in;
      kind2_ff   <= kind2_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
   end

   `LRTS_ASSERT_NEXT(a_tick_wraps, clock, reset, req_acc && (req_op == OP_TICK) && playing_ff, state_ff == ST_WRAP, "playing tick did not start the walk")
   `LRTS_ASSERT_NOW(a_stage_in_walk, clock, reset, v1_ff || v2_ff, state_ff == ST_WALK, "walk pipeline busy outside the walk")
   `LRTS_ASSERT_NOW(a_stop_needs_fire, clock, reset, 1'b1, (stopped_ff & ~fired_ff) == '0, "stopped mark without fired mark")
   `LRTS_ASSERT_NOW(a_evt_limit, clock, reset, 1'b1, evt_cnt_ff <= EVT_CNT_W'(MAX_EVENTS), "event count past limit")

endmodule

FILE: design/loop_region_trigger_sequencer_unit.sv
// Loop region trigger sequencer: write, toggle and stopped-tick requests are handled in
// the idle state as they are accepted. A tick request while playing is accepted, then
// passes the loop wrap check; the walk then reads one slot per cycle, when not stalled,
// from the single-read-port region memory until its two-stage pipeline is empty, and
// a drain state hands over the final event. The walk stalls while the response side
// holds back events. Every slot is read by the walk, but the used flags reset to zero,
// so the contents of never-written slots are ignored and no memory clearing follows reset.
//
// Top level: configuration registers and request unpacking; instantiates
// lrts_sequencer and lrts_event_out, uses lrts_pkg.
module loop_region_trigger_sequencer_unit (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: elapsed[29:0], slot[34:30], start_pos[50:35], span[66:51],
   //        is_midi[67], enable_slot[68], zero pad[71:69]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lrts_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: op[1:0]
   input  logic [lrts_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: event_slot[4:0], zero pad[7:5]
   output logic [lrts_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: event_kind[1:0]
   output logic [lrts_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [lrts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lrts_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lrts_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   req_type     req;
   evt_ctl_type ctl;
   logic        evt_room;

   assign req = req_tdata[$bits(req_type)-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LOOP_BEGIN:  cfg_in.loop_begin  = csr_wdata[POS_W-1:0];
            CSR_LOOP_FINISH: cfg_in.loop_finish = csr_wdata[POS_W-1:0];
            CSR_UNIT_TIME:   cfg_in.unit_time   = csr_wdata[UT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loop_begin  <= LOOP_BEGIN_RST;
         cfg_ff.loop_finish <= LOOP_FINISH_RST;
         cfg_ff.unit_time   <= UNIT_TIME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lrts_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req        (req),
      .ctl        (ctl),
      .evt_room   (evt_room)
   );

   lrts_event_out u_out (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .evt_room   (evt_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: tb/sv/lrts_tb_pkg.sv
`timescale 1ns / 1ps
// Event scoreboard for the loop region trigger sequencer testbench.
// It predicts the trigger events of every accepted request and checks the events that come out.
// Depends on lrts_pkg for widths, codes and the request layout.
package lrts_tb_pkg;
   import lrts_pkg::*;

   typedef struct {
      logic [EVT_SLOT_W-1:0] slot;
      logic [KIND_W-1:0]     kind;
      logic                  last;
   } region_event;

   class region_event_board;
      logic [POS_W-1:0]  loop_begin;
      logic [POS_W-1:0]  loop_finish;
      logic [UT_W-1:0]   unit_time;
      logic [PH_W-1:0]   playhead;
      bit                playing;
      logic [POS_W-1:0]  region_start [REGION_SLOTS];
      logic [POS_W-1:0]  region_span [REGION_SLOTS];
      bit                region_midi [REGION_SLOTS];
      bit                region_used [REGION_SLOTS];
      bit                fired_mark [REGION_SLOTS];
      bit                stopped_mark [REGION_SLOTS];
      region_event       pending_events [$];
      int                mismatch_count;

      function new();
         loop_begin     = LOOP_BEGIN_RST;
         loop_finish    = LOOP_FINISH_RST;
         unit_time      = UNIT_TIME_RST;
         playhead       = '0;
         playing        = 1'b0;
         region_start   = '{default: '0};
         region_span    = '{default: '0};
         region_midi    = '{default: 1'b0};
         region_used    = '{default: 1'b0};
         fired_mark     = '{default: 1'b0};
         stopped_mark   = '{default: 1'b0};
         mismatch_count = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_LOOP_BEGIN:  loop_begin  = value[POS_W-1:0];
            CSR_LOOP_FINISH: loop_finish = value[POS_W-1:0];
            CSR_UNIT_TIME:   unit_time   = value[UT_W-1:0];
            default: ;
         endcase
      endfunction

      function void flag_mismatch(string text);
         mismatch_count++;
         if (mismatch_count <= 10) $display("%s", text);
      endfunction

      function void queue_event(region_event ev);
         pending_events = {pending_events, ev};
      endfunction

      // Applies one accepted request and queues the events that a tick causes.
      function void note_request(logic [OP_W-1:0] op, req_type req);
         logic [63:0] loop_end;
         logic [63:0] r_start;
         logic [63:0] r_stop;
         region_event ev;
         int          first_new;
         case (op)
            OP_WRITE: begin
               region_start[req.slot] = req.start_pos;
               region_span[req.slot]  = req.span;
               region_midi[req.slot]  = req.is_midi;
               region_used[req.slot]  = req.enable_slot;
               fired_mark[req.slot]   = 1'b0;
               stopped_mark[req.slot] = 1'b0;
            end
            OP_TOGGLE: begin
               fired_mark   = '{default: 1'b0};
               stopped_mark = '{default: 1'b0};
               playing      = !playing;
            end
            OP_TICK: begin
               if (playing) begin
                  playhead = playhead + PH_W'(req.elapsed);
                  loop_end = 64'(loop_finish) * 64'(unit_time);
                  if (64'(playhead) > loop_end) begin
                     playhead     = PH_W'(64'(loop_begin) * 64'(unit_time));
                     fired_mark   = '{default: 1'b0};
                     stopped_mark = '{default: 1'b0};
                  end
                  first_new = pending_events.size();
                  for (int s = 0; s < REGION_SLOTS; s++) begin
                     if (!region_used[s]) continue;
                     r_start = 64'(region_start[s]) * 64'(unit_time);
                     r_stop  = r_start + 64'(region_span[s]) * 64'(unit_time);
                     ev.slot = EVT_SLOT_W'(s);
                     ev.last = 1'b0;
                     if (!fired_mark[s] && 64'(playhead) >= r_start
                         && 64'(playhead) < r_stop) begin
                        fired_mark[s] = 1'b1;
                        ev.kind = region_midi[s] ? EV_MIDI_ON : EV_SAMPLE_ON;
                        queue_event(ev);
                     end else if (fired_mark[s] && !stopped_mark[s]
                                  && 64'(playhead) > r_stop) begin
                        // A sample region ends without a note-off.
                        stopped_mark[s] = 1'b1;
                        if (region_midi[s]) begin
                           ev.kind = EV_MIDI_OFF;
                           queue_event(ev);
                        end
                     end
                  end
                  if (pending_events.size() > first_new)
                     pending_events[pending_events.size() - 1].last = 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_event(logic [EVT_SLOT_W-1:0] slot, logic [KIND_W-1:0] kind,
                                logic last);
         region_event want;
         if (pending_events.size() == 0) begin
            flag_mismatch($sformatf("unexpected event: slot %0d kind %0d last %0b",
                                    slot, kind, last));
            return;
         end
         want = pending_events.pop_front();
         if (want.slot !== slot || want.kind !== kind || want.last !== last)
            flag_mismatch($sformatf({"event mismatch: expected slot %0d kind %0d last %0b,",
                                     " got slot %0d kind %0d last %0b"},
                                    want.slot, want.kind, want.last, slot, kind, last));
      endfunction

      function void check_drained();
         if (pending_events.size() != 0)
            flag_mismatch($sformatf("%0d expected events never arrived",
                                    pending_events.size()));
      endfunction
   endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top level of the loop region trigger sequencer testbench: clock, reset, request
// and register drivers, response stall pattern and watchdog. Depends on lrts_pkg,
// lrts_tb_pkg and the loop_region_trigger_sequencer_unit RTL.
module tb_top;
   import lrts_pkg::*;
   import lrts_tb_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_LIMIT    = 5000;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 600;
   localparam logic [63:0] ELAPSED_MAX = 64'h3FFF_FFFF;

   typedef struct {
      logic [POS_W-1:0] loop_begin;
      logic [POS_W-1:0] loop_finish;
      logic [UT_W-1:0]  unit_time;
      int               base;
      int               spread;
      int               step;
      int               count;
      int               hold_at;
   } phase_plan;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   region_event_board board;
   bit                rsp_hold_request;
   int                idle_cycles;
   phase_plan         plans [6];

   loop_region_trigger_sequencer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_event(rsp_tdata[EVT_SLOT_W-1:0], rsp_tuser, rsp_tlast);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: runs of random stall density, plus one long hold on request.
   initial begin
      int ready_pct;
      int pattern_left;
      rsp_tready   = 1'b0;
      ready_pct    = 100;
      pattern_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (pattern_left == 0) begin
               case ($urandom_range(0, 2))
                  0: ready_pct = 100;
                  1: ready_pct = 60;
                  default: ready_pct = 20;
               endcase
               pattern_left = $urandom_range(16, 160);
            end
            pattern_left--;
            rsp_tready <= ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input req_type req);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'(req);
      do @(posedge clock); while (!req_tready);
      board.note_request(op, req);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // A tick that causes no event may still be walking the slots, so wait past it.
   task automatic drain_and_settle();
      pause_sender(1);
      while (board.pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_register(index, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_type region_request(logic [IN_SLOT_W-1:0] slot,
                                              logic [POS_W-1:0] start, logic [POS_W-1:0] span,
                                              logic midi, logic used);
      req_type r;
      r = '0;
      r.slot        = slot;
      r.start_pos   = start;
      r.span        = span;
      r.is_midi     = midi;
      r.enable_slot = used;
      return r;
   endfunction

   function automatic req_type tick_request(logic [ELAPSED_W-1:0] elapsed);
      req_type r;
      r = '0;
      r.elapsed = elapsed;
      return r;
   endfunction

   task automatic random_request(input phase_plan p);
      req_type          r;
      int               roll;
      logic [63:0]      wait_time;
      logic [OP_W-1:0]  op;
      roll          = $urandom_range(0, 99);
      r.elapsed     = ELAPSED_W'($urandom);
      r.slot        = IN_SLOT_W'($urandom);
      r.start_pos   = POS_W'($urandom);
      r.span        = POS_W'($urandom);
      r.is_midi     = 1'($urandom);
      r.enable_slot = 1'($urandom);
      if (!board.playing && roll < 50) begin
         op = OP_TOGGLE;
      end else if (roll < 3) begin
         op = OP_TOGGLE;
      end else if (roll < 5) begin
         op = OP_UNUSED;
      end else if (roll < 30) begin
         op = OP_WRITE;
         // Most writes place a region inside the loop so that ticks reach it.
         if (roll >= 8) begin
            r.start_pos   = POS_W'(p.base + int'($urandom_range(0, p.spread)));
            r.span        = POS_W'($urandom_range(1, p.spread / 3 + 1));
            r.enable_slot = ($urandom_range(0, 9) != 0);
         end
      end else begin
         op = OP_TICK;
         if (roll >= 36) begin
            wait_time = 64'($urandom_range(0, p.step)) * 64'(board.unit_time)
                        + 64'($urandom_range(0, 32'(board.unit_time)));
            r.elapsed = (wait_time > ELAPSED_MAX) ? '1 : ELAPSED_W'(wait_time);
         end
      end
      send_request(op, r);
   endtask

   task automatic run_phase(input phase_plan p);
      int burst_left;
      burst_left = 0;
      for (int i = 0; i < p.count; i++) begin
         if (burst_left == 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12)));
            burst_left = $urandom_range(1, 20);
         end
         if (i == p.hold_at) rsp_hold_request = 1'b1;
         random_request(p);
         burst_left--;
      end
   endtask

   initial begin
      board            = new();
      rsp_hold_request = 1'b0;
      idle_cycles      = 0;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = OP_TICK;
      csr_we           = 1'b0;
      csr_index        = CSR_LOOP_BEGIN;
      csr_wdata        = '0;

      plans[0] = '{16'd0,     16'd100,   28'd1,           0,     100, 8,  90, -1};
      plans[1] = '{16'd20,    16'd300,   28'd1000,        20,    280, 15, 90, 20};
      // Loop start beyond loop end: every tick wraps.
      plans[2] = '{16'd65535, 16'd0,     28'd3,           65500, 35,  4,  60, -1};
      plans[3] = '{16'd0,     16'd65535, 28'd0,           0,     100, 4,  30, -1};
      plans[4] = '{16'd0,     16'd65535, 28'hFFF_FFFF,    0,     200, 3,  60, -1};
      plans[5] = '{16'd100,   16'd2000,  28'd240000000,   100,   400, 3,  70, -1};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values.
      send_request(OP_TICK, tick_request('1));
      send_request(OP_UNUSED, '1);
      send_request(OP_WRITE, region_request(5'd0, 16'd0, 16'd1, 1'b1, 1'b1));
      send_request(OP_WRITE, region_request(5'd31, 16'd65535, 16'd65535, 1'b0, 1'b1));
      send_request(OP_WRITE, region_request(5'd5, 16'd10, 16'd5, 1'b0, 1'b1));
      send_request(OP_WRITE, region_request(5'd6, 16'd10, 16'd0, 1'b1, 1'b1));
      send_request(OP_WRITE, region_request(5'd7, 16'd0, 16'd100, 1'b1, 1'b0));
      send_request(OP_TOGGLE, '0);
      send_request(OP_TICK, tick_request('0));
      // Exactly at the region stop nothing happens; one past it ends the note.
      send_request(OP_TICK, tick_request(30'd2000000));
      send_request(OP_TICK, tick_request(30'd1));
      send_request(OP_TICK, tick_request(30'd17999999));
      send_request(OP_WRITE, region_request(5'd5, 16'd10, 16'd5, 1'b0, 1'b1));
      send_request(OP_TICK, tick_request('0));
      send_request(OP_TICK, tick_request('1));
      send_request(OP_TICK, tick_request('1));
      send_request(OP_WRITE, region_request(5'd0, 16'd0, 16'd1, 1'b1, 1'b0));
      send_request(OP_TOGGLE, '0);
      send_request(OP_TICK, tick_request(30'd5));
      send_request(OP_TOGGLE, '0);
      send_request(OP_WRITE, region_request(5'd3, 16'd0, 16'd2, 1'b0, 1'b1));
      send_request(OP_TICK, tick_request('0));

      foreach (plans[k]) begin
         drain_and_settle();
         write_register(CSR_LOOP_BEGIN, CSR_DATA_W'(plans[k].loop_begin));
         write_register(CSR_LOOP_FINISH, CSR_DATA_W'(plans[k].loop_finish));
         write_register(CSR_UNIT_TIME, CSR_DATA_W'(plans[k].unit_time));
         run_phase(plans[k]);
      end

      drain_and_settle();
      board.check_drained();
      if (board.mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
